[rtl/mcd_pkg.sv]
// mcd_pkg: shared types and constants of the maze carver
// no dependencies
`default_nettype none

package mcd_pkg;

    typedef enum logic [2:0] {
        KIND_STARTED,
        KIND_CARVED,
        KIND_BACKTRACKED,
        KIND_FINISHED,
        KIND_READ,
        KIND_REJECTED
    } kind_t;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    localparam logic [5:0] GRID_RESET = 6'd32;

    typedef struct packed {
        logic       any;
        logic [1:0] dir;
    } pick_t;

    // opening bit of a direction: bit3 for direction 0 down to bit0 for direction 3
    function automatic logic [3:0] open_bit(input logic [1:0] dir);
        return 4'b1000 >> dir;
    endfunction

endpackage

`default_nettype wire

[rtl/mcd_ram.sv]
// mcd_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module mcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[rtl/mcd_pick.sv]
// mcd_pick: picks one candidate direction by random value mod candidate count
// depends on mcd_pkg
`default_nettype none

module mcd_pick (
    input  logic [3:0]     cand,
    input  logic [7:0]     rnd,
    output mcd_pkg::pick_t pick
);
    import mcd_pkg::*;

    logic [2:0] count;
    logic [3:0] digit_sum;
    logic [1:0] mod3;
    logic [1:0] sel;

    assign count = {2'b00, cand[0]} + {2'b00, cand[1]} + {2'b00, cand[2]} + {2'b00, cand[3]};

    // 4 is 1 mod 3, so base-4 digits sum to the same residue
    assign digit_sum = {2'b00, rnd[1:0]} + {2'b00, rnd[3:2]}
                     + {2'b00, rnd[5:4]} + {2'b00, rnd[7:6]};

    always_comb
    begin
        case (digit_sum)
            4'd1, 4'd4, 4'd7, 4'd10: mod3 = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11: mod3 = 2'd2;
            default:                 mod3 = 2'd0;
        endcase
    end

    always_comb
    begin
        case (count)
            3'd2:    sel = {1'b0, rnd[0]};
            3'd3:    sel = mod3;
            3'd4:    sel = rnd[1:0];
            default: sel = 2'd0;
        endcase
    end

    always_comb
    begin
        logic [1:0] seen;
        logic       hit;
        seen     = 2'd0;
        hit      = 1'b0;
        pick.dir = 2'd0;
        for (int d = 0; d < 4; d++)
        begin
            if (cand[d])
            begin
                if (!hit && seen == sel)
                begin
                    pick.dir = 2'(d);
                    hit      = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
        pick.any = |cand;
    end

endmodule

`default_nettype wire

[rtl/maze_carver_dfs.sv]
// maze_carver_dfs: randomized depth-first maze carver, top level
// depends on mcd_pkg, mcd_ram (cell and path stack memories), mcd_pick
`default_nettype none

// One item is taken at a time. The cell memory (visited bit and opening mask
// per cell) is a single-port ram, and it sets the timing. A step reads the
// current cell and its four neighbours in S_SCAN, decides in S_DECIDE, and
// then writes the carved neighbour in S_WR_NB or reads the path stack in
// S_POP_WAIT before S_OUT loads the result beat into the output register;
// a step that pops the last cell goes from S_DECIDE to S_OUT. A cell read
// passes through S_RD_WAIT; a rejected item or a step on an empty stack goes
// straight to S_OUT. A start sweeps the whole cell memory once, one entry per
// cycle, in S_CLEAR. s_tready rises again on the edge that loads the result,
// so the next item can be taken in S_IDLE; a result held by a low m_tready
// only stalls the next item when that item reaches its own output step. After
// reset the same sweep runs with s_tready low; configuration writes are taken
// at any time.
module maze_carver_dfs #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cell_row, cell_col, random_value, zero pad
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_row, out_col, carve_direction, opening_mask
    output logic [2:0]  m_tuser    // result_kind
);
    import mcd_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam int SW    = RW + CW;
    localparam int MW    = (RW > CW) ? RW : CW;
    localparam int XW    = ((MW > 6) ? MW : 6) + 2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WR_NB,
        S_POP_WAIT,
        S_RD_WAIT,
        S_OUT
    } state_t;

    function automatic logic [AW-1:0] calc_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(MAX_COLS) + AW'(col);
    endfunction

    function automatic logic [4:0] row5(input logic [RW-1:0] row);
        logic [XW-1:0] t;
        t = XW'(row);
        return t[4:0];
    endfunction

    function automatic logic [4:0] col5(input logic [CW-1:0] col);
        logic [XW-1:0] t;
        t = XW'(col);
        return t[4:0];
    endfunction

    // control and output registers
    state_t          state_reg, state_next;
    logic            clr_start_reg, clr_start_next;
    logic [AW-1:0]   clr_ctr_reg, clr_ctr_next;
    logic [2:0]      scan_ctr_reg, scan_ctr_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [5:0]      row_cnt_reg, row_cnt_next;
    logic [5:0]      col_cnt_reg, col_cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [15:0]     m_tdata_reg, m_tdata_next;
    logic [2:0]      m_tuser_reg, m_tuser_next;

    // payload registers
    logic [RW-1:0]   st_row_reg, st_row_next;
    logic [CW-1:0]   st_col_reg, st_col_next;
    logic [AW-1:0]   start_addr_reg, start_addr_next;
    logic [7:0]      rnd_reg, rnd_next;
    logic [3:0]      cand_reg, cand_next;
    logic [3:0]      cur_mask_reg, cur_mask_next;
    logic [3:0]      nb_mask_reg [4];
    logic [3:0]      nb_mask_next [4];
    logic [1:0]      dir_reg, dir_next;
    kind_t           res_kind_reg, res_kind_next;
    logic [4:0]      res_row_reg, res_row_next;
    logic [4:0]      res_col_reg, res_col_next;
    logic [1:0]      res_dir_reg, res_dir_next;
    logic [3:0]      res_mask_reg, res_mask_next;

    // memory ports
    logic            cell_we;
    logic [AW-1:0]   cell_addr;
    logic [4:0]      cell_wdata;
    logic [4:0]      cell_rdata;
    logic            stk_we;
    logic [AW-1:0]   stk_addr;
    logic [SW-1:0]   stk_wdata;
    logic [SW-1:0]   stk_rdata;

    // decoded inputs and grid
    logic [XW-1:0]   rows_x, cols_x;
    logic [XW-1:0]   in_row_x, in_col_x;
    logic [RW-1:0]   in_row;
    logic [CW-1:0]   in_col;
    logic            in_ok;
    logic [XW-1:0]   cur_row_x, cur_col_x;
    logic [XW-1:0]   row_up_x, row_dn_x, col_up_x, col_dn_x;
    logic [AW-1:0]   cur_addr;
    logic [RW-1:0]   nb_row [4];
    logic [CW-1:0]   nb_col [4];
    logic            nb_ok [4];
    logic [AW-1:0]   nb_addr [4];
    logic [DW-1:0]   depth_m2;
    pick_t           pick;

    mcd_ram #(
        .WIDTH (5),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .addr  (cell_addr),
        .wdata (cell_wdata),
        .rdata (cell_rdata)
    );

    mcd_ram #(
        .WIDTH (SW),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    mcd_pick u_pick (
        .cand (cand_reg),
        .rnd  (rnd_reg),
        .pick (pick)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // grid size in use: zero counts as one, clamp at the maximum
    always_comb
    begin
        if (row_cnt_reg == 6'd0)
            rows_x = XW'(1);
        else if (XW'(row_cnt_reg) > XW'(MAX_ROWS))
            rows_x = XW'(MAX_ROWS);
        else
            rows_x = XW'(row_cnt_reg);
        if (col_cnt_reg == 6'd0)
            cols_x = XW'(1);
        else if (XW'(col_cnt_reg) > XW'(MAX_COLS))
            cols_x = XW'(MAX_COLS);
        else
            cols_x = XW'(col_cnt_reg);
    end

    assign in_row_x = XW'(s_tdata[4:0]);
    assign in_col_x = XW'(s_tdata[9:5]);
    assign in_row   = in_row_x[RW-1:0];
    assign in_col   = in_col_x[CW-1:0];
    assign in_ok    = (in_row_x < rows_x) && (in_col_x < cols_x);

    assign cur_row_x = XW'(cur_row_reg);
    assign cur_col_x = XW'(cur_col_reg);
    assign row_up_x  = cur_row_x + XW'(1);
    assign row_dn_x  = cur_row_x - XW'(1);
    assign col_up_x  = cur_col_x + XW'(1);
    assign col_dn_x  = cur_col_x - XW'(1);
    assign cur_addr  = calc_addr(cur_row_reg, cur_col_reg);
    assign depth_m2  = depth_reg - DW'(2);

    // neighbours in direction order
    always_comb
    begin
        nb_row[0] = row_up_x[RW-1:0];
        nb_col[0] = cur_col_reg;
        nb_ok[0]  = row_up_x < rows_x;
        nb_row[1] = cur_row_reg;
        nb_col[1] = col_up_x[CW-1:0];
        nb_ok[1]  = col_up_x < cols_x;
        nb_row[2] = row_dn_x[RW-1:0];
        nb_col[2] = cur_col_reg;
        nb_ok[2]  = (cur_row_x != '0) && (row_dn_x < rows_x);
        nb_row[3] = cur_row_reg;
        nb_col[3] = col_dn_x[CW-1:0];
        nb_ok[3]  = (cur_col_x != '0) && (col_dn_x < cols_x);
        for (int d = 0; d < 4; d++)
        begin
            nb_addr[d] = nb_ok[d] ? calc_addr(nb_row[d], nb_col[d]) : cur_addr;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_start_next  = clr_start_reg;
        clr_ctr_next    = clr_ctr_reg;
        scan_ctr_next   = scan_ctr_reg;
        depth_next      = depth_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        row_cnt_next    = row_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        st_row_next     = st_row_reg;
        st_col_next     = st_col_reg;
        start_addr_next = start_addr_reg;
        rnd_next        = rnd_reg;
        cand_next       = cand_reg;
        cur_mask_next   = cur_mask_reg;
        nb_mask_next    = nb_mask_reg;
        dir_next        = dir_reg;
        res_kind_next   = res_kind_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        res_dir_next    = res_dir_reg;
        res_mask_next   = res_mask_reg;
        cell_we         = 1'b0;
        cell_addr       = cur_addr;
        cell_wdata      = 5'd0;
        stk_we          = 1'b0;
        stk_addr        = depth_reg[AW-1:0];
        stk_wdata       = {cur_row_reg, cur_col_reg};

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_ROW_COUNT: row_cnt_next = cfg_wdata;
                REG_COL_COUNT: col_cnt_next = cfg_wdata;
                default:       row_cnt_next = row_cnt_reg;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                cell_we   = 1'b1;
                cell_addr = clr_ctr_reg;
                cell_wdata = (clr_start_reg && clr_ctr_reg == start_addr_reg) ? 5'b10000 : 5'd0;
                clr_ctr_next = clr_ctr_reg + AW'(1);
                if (clr_ctr_reg == AW'(CELLS - 1))
                begin
                    clr_ctr_next = '0;
                    if (clr_start_reg)
                    begin
                        cur_row_next  = st_row_reg;
                        cur_col_next  = st_col_reg;
                        depth_next    = DW'(1);
                        res_kind_next = KIND_STARTED;
                        res_row_next  = row5(st_row_reg);
                        res_col_next  = col5(st_col_reg);
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                res_kind_next = KIND_REJECTED;
                res_row_next  = row5(cur_row_reg);
                res_col_next  = col5(cur_col_reg);
                res_dir_next  = 2'd0;
                res_mask_next = 4'd0;
                st_row_next   = in_row;
                st_col_next   = in_col;
                rnd_next      = s_tdata[17:10];
                if (s_tvalid)
                begin
                    state_next = S_OUT;
                    case (s_tuser)
                        OP_START:
                        begin
                            if (in_ok)
                            begin
                                start_addr_next = calc_addr(in_row, in_col);
                                stk_we          = 1'b1;
                                stk_addr        = '0;
                                stk_wdata       = {in_row, in_col};
                                clr_start_next  = 1'b1;
                                clr_ctr_next    = '0;
                                state_next      = S_CLEAR;
                            end
                        end
                        OP_STEP:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_kind_next = KIND_FINISHED;
                            end
                            else
                            begin
                                scan_ctr_next = 3'd0;
                                state_next    = S_SCAN;
                            end
                        end
                        OP_READ:
                        begin
                            if (in_ok)
                            begin
                                cell_addr  = calc_addr(in_row, in_col);
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read current cell then neighbours, data lands in the following cycle
                case (scan_ctr_reg)
                    3'd1:    cell_addr = nb_addr[0];
                    3'd2:    cell_addr = nb_addr[1];
                    3'd3:    cell_addr = nb_addr[2];
                    3'd4:    cell_addr = nb_addr[3];
                    default: cell_addr = cur_addr;
                endcase
                case (scan_ctr_reg)
                    3'd1:
                    begin
                        cur_mask_next = cell_rdata[3:0];
                    end
                    3'd2:
                    begin
                        nb_mask_next[0] = cell_rdata[3:0];
                        cand_next[0]    = nb_ok[0] && !cell_rdata[4];
                    end
                    3'd3:
                    begin
                        nb_mask_next[1] = cell_rdata[3:0];
                        cand_next[1]    = nb_ok[1] && !cell_rdata[4];
                    end
                    3'd4:
                    begin
                        nb_mask_next[2] = cell_rdata[3:0];
                        cand_next[2]    = nb_ok[2] && !cell_rdata[4];
                    end
                    3'd5:
                    begin
                        nb_mask_next[3] = cell_rdata[3:0];
                        cand_next[3]    = nb_ok[3] && !cell_rdata[4];
                    end
                    default:
                    begin
                        cand_next = cand_reg;
                    end
                endcase
                scan_ctr_next = scan_ctr_reg + 3'd1;
                if (scan_ctr_reg == 3'd5)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (pick.any)
                begin
                    if (depth_reg >= DW'(CELLS))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cell_we    = 1'b1;
                        cell_addr  = cur_addr;
                        cell_wdata = {1'b1, cur_mask_reg | open_bit(pick.dir)};
                        stk_we     = 1'b1;
                        stk_addr   = depth_reg[AW-1:0];
                        stk_wdata  = {nb_row[pick.dir], nb_col[pick.dir]};
                        depth_next = depth_reg + DW'(1);
                        dir_next   = pick.dir;
                        state_next = S_WR_NB;
                    end
                end
                else
                begin
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1))
                    begin
                        res_kind_next = KIND_FINISHED;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        stk_addr   = depth_m2[AW-1:0];
                        state_next = S_POP_WAIT;
                    end
                end
            end

            S_WR_NB:
            begin
                cell_we       = 1'b1;
                cell_addr     = nb_addr[dir_reg];
                cell_wdata    = {1'b1, nb_mask_reg[dir_reg] | open_bit(dir_reg + 2'd2)};
                cur_row_next  = nb_row[dir_reg];
                cur_col_next  = nb_col[dir_reg];
                res_kind_next = KIND_CARVED;
                res_row_next  = row5(nb_row[dir_reg]);
                res_col_next  = col5(nb_col[dir_reg]);
                res_dir_next  = dir_reg;
                state_next    = S_OUT;
            end

            S_POP_WAIT:
            begin
                cur_row_next  = stk_rdata[SW-1:CW];
                cur_col_next  = stk_rdata[CW-1:0];
                res_kind_next = KIND_BACKTRACKED;
                res_row_next  = row5(stk_rdata[SW-1:CW]);
                res_col_next  = col5(stk_rdata[CW-1:0]);
                state_next    = S_OUT;
            end

            S_RD_WAIT:
            begin
                res_kind_next = KIND_READ;
                res_row_next  = row5(st_row_reg);
                res_col_next  = col5(st_col_reg);
                res_mask_next = cell_rdata[3:0];
                state_next    = S_OUT;
            end

            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_mask_reg, res_dir_reg, res_col_reg, res_row_reg};
                    m_tuser_next  = res_kind_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_start_reg <= 1'b0;
            clr_ctr_reg   <= '0;
            scan_ctr_reg  <= 3'd0;
            depth_reg     <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            row_cnt_reg   <= GRID_RESET;
            col_cnt_reg   <= GRID_RESET;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= 16'd0;
            m_tuser_reg   <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_start_reg <= clr_start_next;
            clr_ctr_reg   <= clr_ctr_next;
            scan_ctr_reg  <= scan_ctr_next;
            depth_reg     <= depth_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tuser_reg   <= m_tuser_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_row_reg     <= st_row_next;
        st_col_reg     <= st_col_next;
        start_addr_reg <= start_addr_next;
        rnd_reg        <= rnd_next;
        cand_reg       <= cand_next;
        cur_mask_reg   <= cur_mask_next;
        nb_mask_reg    <= nb_mask_next;
        dir_reg        <= dir_next;
        res_kind_reg   <= res_kind_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        res_dir_reg    <= res_dir_next;
        res_mask_reg   <= res_mask_next;
    end

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(CELLS))
        else $error("stack depth above cell count");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !cell_we)
        else $error("cell memory written during neighbour scan");

    a_carve_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_NB) |=> (state_reg == S_OUT && res_kind_reg == KIND_CARVED))
        else $error("carve not reported");

    a_cur_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_x < XW'(MAX_ROWS)) && (cur_col_x < XW'(MAX_COLS)))
        else $error("current cell outside storage");
`endif

endmodule

`default_nettype wire
